FILE: rtl/w2s_pkg.sv
// Shared constants, types and helpers for the world-to-screen projection core.
// Depends on nothing; every other file in rtl/ depends on it.
package w2s_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int WORD_W    = 32;
    localparam int SIZE_W    = 15;
    localparam int IDX_W     = 4;
    localparam int MAT_DIM   = 4;
    localparam int MAT_N     = MAT_DIM * MAT_DIM;
    localparam int CFG_IDX_W = 2;

    // Quotient bits produced by the divider; larger quotients clamp to 2^QBITS.
    localparam int QBITS = 40;

    // Pipeline stage positions.
    localparam int ST_PROD = 0;
    localparam int ST_SUM  = 1;
    localparam int ST_MAG  = 2;
    localparam int ST_MUL  = 3;
    localparam int ST_INIT = 4;
    localparam int ST_DIV  = 5;
    localparam int ST_OUT  = ST_DIV + QBITS;
    localparam int NSTG    = ST_OUT + 1;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PROJECT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 15'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 15'd1080;

    typedef logic [NSTG-1:0] t_stage_en;

    // Matrix column feeding each of the three dot products: x, y, then w.
    function automatic int col_sel(input int c);
        return (c == 2) ? 3 : c;
    endfunction

endpackage

FILE: rtl/w2s_in_if.sv
// Request channel carrying matrix loads and world points into the core.
// Depends on w2s_pkg for field widths.
interface w2s_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [w2s_pkg::IDX_W-1:0]           entry_index;
    logic signed [w2s_pkg::WORD_W-1:0]   entry_value;
    logic signed [w2s_pkg::WORD_W-1:0]   point_x;
    logic signed [w2s_pkg::WORD_W-1:0]   point_y;
    logic signed [w2s_pkg::WORD_W-1:0]   point_z;

    modport source (output valid, action, entry_index, entry_value, point_x, point_y,
                    point_z, input ready);
    modport sink (input valid, action, entry_index, entry_value, point_x, point_y,
                  point_z, output ready);
endinterface

FILE: rtl/w2s_out_if.sv
// Result channel carrying projected screen coordinates out of the core.
// Depends on w2s_pkg for field widths.
interface w2s_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [w2s_pkg::WORD_W-1:0]   screen_x;
    logic signed [w2s_pkg::WORD_W-1:0]   screen_y;
    logic                                behind_camera;

    modport source (output valid, screen_x, screen_y, behind_camera, input ready);
    modport sink (input valid, screen_x, screen_y, behind_camera, output ready);
endinterface

FILE: rtl/w2s_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on w2s_pkg for field widths.
interface w2s_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [w2s_pkg::CFG_IDX_W-1:0]      index;
    logic [w2s_pkg::SIZE_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/w2s_transform.sv
// View matrix store and the first two pipeline stages: nine products, then
// three dot-product sums (x, y, w). Depends on w2s_pkg.
module w2s_transform #(
    parameter int FRAC_BITS = w2s_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  w2s_pkg::t_stage_en                          i_en,
    input  logic                                        i_load,
    input  logic [w2s_pkg::IDX_W-1:0]                   i_entry_index,
    input  logic signed [w2s_pkg::WORD_W-1:0]           i_entry_value,
    input  logic signed [w2s_pkg::WORD_W-1:0]           i_point_x,
    input  logic signed [w2s_pkg::WORD_W-1:0]           i_point_y,
    input  logic signed [w2s_pkg::WORD_W-1:0]           i_point_z,
    output logic signed [2*w2s_pkg::WORD_W+1-FRAC_BITS:0] o_xv,
    output logic signed [2*w2s_pkg::WORD_W+1-FRAC_BITS:0] o_yv,
    output logic signed [2*w2s_pkg::WORD_W+1-FRAC_BITS:0] o_w
);
    import w2s_pkg::*;

    localparam int VW = 2*WORD_W + 2 - FRAC_BITS;

    logic signed [WORD_W-1:0]   r_mat  [MAT_N];
    logic signed [WORD_W-1:0]   w_pt   [3];
    logic signed [2*WORD_W-1:0] w_prod [3][3];
    logic signed [2*WORD_W-1:0] r_prod [3][3];
    logic signed [WORD_W-1:0]   r_tr   [3];
    logic signed [VW-1:0]       r_sum  [3];
    logic signed [2*WORD_W-1:0] w_sh   [3][3];

    assign w_pt[0] = i_point_x;
    assign w_pt[1] = i_point_y;
    assign w_pt[2] = i_point_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < MAT_N; e++) begin
                r_mat[e] <= '0;
            end
        end else if (i_load) begin
            r_mat[i_entry_index] <= i_entry_value;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                w_prod[c][r] = r_mat[IDX_W'(r*MAT_DIM + col_sel(c))] * w_pt[r];
                w_sh[c][r]   = r_prod[c][r] >>> FRAC_BITS;
            end
        end
    end

    // A projection reads the matrix as it stands before a load in the same edge.
    always_ff @(posedge i_clk) begin
        if (i_en[ST_PROD]) begin
            for (int c = 0; c < 3; c++) begin
                r_tr[c] <= r_mat[IDX_W'((MAT_DIM-1)*MAT_DIM + col_sel(c))];
                for (int r = 0; r < 3; r++) begin
                    r_prod[c][r] <= w_prod[c][r];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[ST_SUM]) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= VW'(r_tr[c]) + VW'(w_sh[c][0]) + VW'(w_sh[c][1])
                          + VW'(w_sh[c][2]);
            end
        end
    end

    assign o_xv = r_sum[0];
    assign o_yv = r_sum[1];
    assign o_w  = r_sum[2];

endmodule

FILE: rtl/w2s_axis.sv
// One screen axis: magnitude, scale by screen size, restoring division by 2w
// one quotient bit per stage, then centre offset and saturation. Depends on w2s_pkg.
module w2s_axis #(
    parameter int FRAC_BITS = w2s_pkg::FRAC_BITS_DEF,
    parameter bit NEGATE    = 1'b0
) (
    input  logic                                          i_clk,
    input  w2s_pkg::t_stage_en                            i_en,
    input  logic [w2s_pkg::SIZE_W-1:0]                    i_size,
    input  logic signed [2*w2s_pkg::WORD_W+1-FRAC_BITS:0] i_v,
    input  logic signed [2*w2s_pkg::WORD_W+1-FRAC_BITS:0] i_w,
    output logic signed [w2s_pkg::WORD_W-1:0]             o_coord
);
    import w2s_pkg::*;

    localparam int VW  = 2*WORD_W + 2 - FRAC_BITS;
    localparam int NW  = SIZE_W + VW;
    localparam int NLW = NW + FRAC_BITS;
    localparam int HW  = NLW - QBITS;
    localparam int RW  = QBITS + 3;

    localparam logic signed [RW-1:0] SAT_HI = {{(RW-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO = {{(RW-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
    localparam logic [RW-1:0]        Q_CAP  = RW'(1) << QBITS;

    logic [VW-1:0]  r_mag;
    logic           r_neg2;
    logic [VW-1:0]  r_d2;
    logic [NW-1:0]  w_num;
    logic [NW-1:0]  r_num;
    logic           r_neg3;
    logic [VW-1:0]  r_d3;
    logic [NLW-1:0] w_nfull;
    logic [HW-1:0]  w_hi;

    logic [VW-1:0]    r_rem [QBITS+1];
    logic [VW-1:0]    r_d   [QBITS+1];
    logic [QBITS-1:0] r_lo  [QBITS+1];
    logic [QBITS-1:0] r_q   [QBITS+1];
    logic             r_neg [QBITS+1];
    logic             r_ovf [QBITS+1];

    logic [RW-1:0]        w_q;
    logic signed [RW-1:0] w_half;
    logic signed [RW-1:0] w_sum;

    always_ff @(posedge i_clk) begin
        if (i_en[ST_MAG]) begin
            r_mag  <= i_v[VW-1] ? VW'(-i_v) : VW'(i_v);
            r_neg2 <= i_v[VW-1] ^ NEGATE;
            r_d2   <= {i_w[VW-2:0], 1'b0};
        end
    end

    assign w_num = i_size * r_mag;

    always_ff @(posedge i_clk) begin
        if (i_en[ST_MUL]) begin
            r_num  <= w_num;
            r_neg3 <= r_neg2;
            r_d3   <= r_d2;
        end
    end

    // The dividend is size * |v| * 2^FRAC_BITS; its top part decides the clamp.
    assign w_nfull = {r_num, {FRAC_BITS{1'b0}}};
    assign w_hi    = w_nfull[NLW-1:QBITS];

    always_ff @(posedge i_clk) begin
        if (i_en[ST_INIT]) begin
            r_ovf[0] <= VW'(w_hi) >= r_d3;
            r_rem[0] <= VW'(w_hi);
            r_lo[0]  <= w_nfull[QBITS-1:0];
            r_q[0]   <= '0;
            r_d[0]   <= r_d3;
            r_neg[0] <= r_neg3;
        end
    end

    for (genvar j = 0; j < QBITS; j++) begin : g_div
        logic [VW:0] w_t;
        logic        w_ge;

        assign w_t  = {r_rem[j], r_lo[j][QBITS-1-j]};
        assign w_ge = w_t >= {1'b0, r_d[j]};

        always_ff @(posedge i_clk) begin
            if (i_en[ST_DIV+j]) begin
                r_rem[j+1] <= w_ge ? VW'(w_t - {1'b0, r_d[j]}) : VW'(w_t);
                r_q[j+1]   <= {r_q[j][QBITS-2:0], w_ge};
                r_lo[j+1]  <= r_lo[j];
                r_d[j+1]   <= r_d[j];
                r_neg[j+1] <= r_neg[j];
                r_ovf[j+1] <= r_ovf[j];
            end
        end
    end

    assign w_q    = r_ovf[QBITS] ? Q_CAP : RW'(r_q[QBITS]);
    assign w_half = $signed(RW'({i_size, {(FRAC_BITS-1){1'b0}}}));
    assign w_sum  = r_neg[QBITS] ? (w_half - $signed(w_q)) : (w_half + $signed(w_q));

    always_ff @(posedge i_clk) begin
        if (i_en[ST_OUT]) begin
            if (w_sum > SAT_HI) begin
                o_coord <= SAT_HI[WORD_W-1:0];
            end else if (w_sum < SAT_LO) begin
                o_coord <= SAT_LO[WORD_W-1:0];
            end else begin
                o_coord <= w_sum[WORD_W-1:0];
            end
        end
    end

endmodule

FILE: rtl/world_to_screen_projection_core.sv
// World-to-screen perspective projection core: top level with the stage control.
// Depends on w2s_pkg, the three channel interfaces, w2s_transform and w2s_axis.
//
// Usage: i_pt carries requests. action = load writes one view matrix entry
// (row*4 + column, signed fixed point) and gives no result; action = project
// takes a world point and gives one result on o_res: screen x and y in signed
// fixed point, saturated, or zero with behind_camera set when w is below 0.098.
// i_cfg writes screen width (index 0) and height (index 1); it is always ready
// and should only be used while no projection is in flight.
// Pipeline: a projection passes five stages of products, sums, magnitude, size
// scaling and clamp test, then the 40 stages of the restoring divider, one
// quotient bit each, and then the output register stage that drives o_res.
// Throughput: one request per cycle while i_pt.ready is high.
// Reset clears the matrix to zeros, sets width 1920 and height 1080 and empties
// the pipeline. When o_res stalls each stage holds its request; empty stages
// still fill, and i_pt.ready falls only when all 46 stages are occupied.
module world_to_screen_projection_core #(
    parameter int FRAC_BITS = w2s_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    w2s_in_if.sink      i_pt,
    w2s_cfg_if.sink     i_cfg,
    w2s_out_if.source   o_res
);
    import w2s_pkg::*;

    localparam int VW = 2*WORD_W + 2 - FRAC_BITS;
    localparam logic signed [VW-1:0] THRESH =
        VW'(((64'sd98 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);

    logic [SIZE_W-1:0]   r_width;
    logic [SIZE_W-1:0]   r_height;
    t_stage_en           w_en;
    logic [NSTG-1:0]     r_v;
    logic [NSTG-1:ST_MAG] r_bh;
    logic                w_acc;
    logic                w_load;
    logic                w_proj;
    logic signed [VW-1:0]     w_xv;
    logic signed [VW-1:0]     w_yv;
    logic signed [VW-1:0]     w_w;
    logic signed [WORD_W-1:0] w_x;
    logic signed [WORD_W-1:0] w_y;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SCREEN_WIDTH:  r_width  <= i_cfg.data;
                REG_SCREEN_HEIGHT: r_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // A stage may advance when some stage at or after it is empty, or the output drains.
    for (genvar k = 0; k < NSTG; k++) begin : g_en
        assign w_en[k] = o_res.ready | ~(&r_v[NSTG-1:k]);
    end

    assign i_pt.ready = w_en[ST_PROD];
    assign w_acc      = i_pt.valid & w_en[ST_PROD];
    assign w_load     = w_acc & (i_pt.action == ACT_LOAD);
    assign w_proj     = w_acc & (i_pt.action == ACT_PROJECT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= w_proj;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MAG]) begin
            r_bh[ST_MAG] <= w_w < THRESH;
        end
        for (int k = ST_MAG + 1; k < NSTG; k++) begin
            if (w_en[k]) begin
                r_bh[k] <= r_bh[k-1];
            end
        end
    end

    w2s_transform #(.FRAC_BITS(FRAC_BITS)) u_transform (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_load        (w_load),
        .i_entry_index (i_pt.entry_index),
        .i_entry_value (i_pt.entry_value),
        .i_point_x     (i_pt.point_x),
        .i_point_y     (i_pt.point_y),
        .i_point_z     (i_pt.point_z),
        .o_xv          (w_xv),
        .o_yv          (w_yv),
        .o_w           (w_w)
    );

    w2s_axis #(.FRAC_BITS(FRAC_BITS), .NEGATE(1'b0)) u_axis_x (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_size  (r_width),
        .i_v     (w_xv),
        .i_w     (w_w),
        .o_coord (w_x)
    );

    w2s_axis #(.FRAC_BITS(FRAC_BITS), .NEGATE(1'b1)) u_axis_y (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_size  (r_height),
        .i_v     (w_yv),
        .i_w     (w_w),
        .o_coord (w_y)
    );

    assign o_res.valid         = r_v[NSTG-1];
    assign o_res.behind_camera = r_bh[NSTG-1];
    assign o_res.screen_x      = r_bh[NSTG-1] ? '0 : w_x;
    assign o_res.screen_y      = r_bh[NSTG-1] ? '0 : w_y;

    a_proj_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proj |=> r_v[ST_PROD])
        else $error("accepted projection did not enter the pipeline");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> !r_v[ST_PROD])
        else $error("matrix load created a pipeline entry");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pt.ready |-> ((&r_v) && !o_res.ready))
        else $error("input stalled while the pipeline had room");

endmodule
